@@ hdl/triac_phase_angle_regulator_assert.svh @@
// Assertion helpers used by the top-level regulator RTL.
`ifndef TRIAC_PHASE_ANGLE_REGULATOR_ASSERT_SVH
`define TRIAC_PHASE_ANGLE_REGULATOR_ASSERT_SVH

// same-cycle implication
`define TPAR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tpar_pkg.sv @@
`default_nettype none

package tpar_pkg;

  localparam logic [6:0]  GATE_LIMIT          = 7'd98;
  localparam logic [6:0]  FULL_DELAY          = 7'd100;
  localparam logic [7:0]  TICK_MAX            = 8'd255;
  localparam logic [15:0] RATED_RESET         = 16'd2000;
  localparam logic [7:0]  HOLDOFF_RESET       = 8'd2;
  localparam logic [15:0] ALPHA_Q16           = 16'd3277;
  localparam logic [15:0] ONE_MINUS_ALPHA_Q16 = 16'd62259;
  localparam logic [21:0] STEP_LIMIT          = 22'd1000;
  localparam logic [21:0] POWER_SCALE         = 22'd100;

  localparam int DIV_W     = 32;
  localparam int DIVISOR_W = 22;
  localparam int AVG_W     = 24;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ZERO_CROSS,
    OP_POWER,
    OP_FORCE_ON,
    OP_FORCE_OFF
  } op_t;

  typedef enum logic [0:0] {
    CFG_RATED,
    CFG_HOLDOFF
  } cfg_index_t;

  typedef enum logic [3:0] {
    R_IDLE,
    R_DIV_STEP,
    R_WAIT_STEP,
    R_DIV_PPS,
    R_WAIT_PPS,
    R_MUL_NEW,
    R_MUL_OLD,
    R_SUM,
    R_ADJUST
  } reg_state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] power;
    logic [15:0] rated;
    logic [6:0]  delay;
  } reg_req_t;

  typedef struct packed {
    logic       done;
    logic [6:0] delay;
  } reg_res_t;

endpackage

`default_nettype wire

@@ hdl/tpar_div.sv @@
`default_nettype none

module tpar_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [tpar_pkg::DIV_W-1:0]     dividend,
  input  wire logic [tpar_pkg::DIVISOR_W-1:0] divisor,
  output logic                                done,
  output logic [tpar_pkg::DIV_W-1:0]          quotient
);

  localparam int CNT_W = $clog2(tpar_pkg::DIV_W);

  logic                           busy;
  logic [CNT_W-1:0]               cnt;
  logic [tpar_pkg::DIVISOR_W-1:0] rem;
  logic [tpar_pkg::DIVISOR_W-1:0] dvs;
  logic [tpar_pkg::DIV_W-1:0]     quo;
  logic [tpar_pkg::DIVISOR_W:0]   trial;
  logic [tpar_pkg::DIVISOR_W:0]   diff;
  logic                           fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem, quo[tpar_pkg::DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= fits ? diff[tpar_pkg::DIVISOR_W-1:0] : trial[tpar_pkg::DIVISOR_W-1:0];
        quo <= {quo[tpar_pkg::DIV_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(tpar_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

@@ hdl/tpar_regulator.sv @@
`default_nettype none

module tpar_regulator (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tpar_pkg::reg_req_t req,
  output tpar_pkg::reg_res_t     res
);

  tpar_pkg::reg_state_t state, state_next;

  logic [15:0] power;
  logic [15:0] rated;
  logic [6:0]  delay_base;
  logic [21:0] step_mag;
  logic [23:0] pps;
  logic [23:0] avg;
  logic [39:0] acc;
  logic [39:0] prod;

  logic        neg;
  logic [15:0] mag;
  logic [21:0] mag100;
  logic [15:0] rated_eff;
  logic        qualify;

  logic        div_start;
  logic [31:0] div_dividend;
  logic [21:0] div_divisor;
  logic        div_done;
  logic [31:0] div_quo;

  logic [15:0] mul_a;
  logic [23:0] mul_b;
  logic [40:0] sum;

  logic        below_avg;
  logic [9:0]  step_c;
  logic signed [11:0] d;
  logic [6:0]  delay_new;

  tpar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    neg       = power[15];
    mag       = neg ? (~power + 16'd1) : power;
    mag100    = {6'b0, mag} * tpar_pkg::POWER_SCALE;
    rated_eff = (rated == 16'd0) ? 16'd1 : rated;
    qualify   = (div_quo != 32'd0) && (neg || (div_quo < 32'(tpar_pkg::GATE_LIMIT)));
    sum       = {1'b0, acc} + {1'b0, prod};
  end

  // delay adjust
  always_comb begin
    below_avg = ({mag, 16'h0} < {8'h0, avg});
    step_c    = (step_mag > tpar_pkg::STEP_LIMIT) ? tpar_pkg::STEP_LIMIT[9:0] : step_mag[9:0];
    if (below_avg && neg) begin
      d = $signed({5'b0, delay_base});
    end else if (below_avg && (mag != 16'd0)) begin
      d = $signed({5'b0, delay_base}) + 12'sd1;
    end else if (neg) begin
      d = $signed({5'b0, delay_base}) - $signed({2'b0, step_c});
    end else begin
      d = $signed({5'b0, delay_base}) + $signed({2'b0, step_c});
    end
    if (d < 12'sd0) begin
      delay_new = 7'd0;
    end else if (d > $signed({5'b0, tpar_pkg::FULL_DELAY})) begin
      delay_new = tpar_pkg::FULL_DELAY;
    end else begin
      delay_new = d[6:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tpar_pkg::R_IDLE: begin
        if (req.start) state_next = tpar_pkg::R_DIV_STEP;
      end
      tpar_pkg::R_DIV_STEP:  state_next = tpar_pkg::R_WAIT_STEP;
      tpar_pkg::R_WAIT_STEP: begin
        if (div_done) state_next = qualify ? tpar_pkg::R_DIV_PPS : tpar_pkg::R_ADJUST;
      end
      tpar_pkg::R_DIV_PPS:   state_next = tpar_pkg::R_WAIT_PPS;
      tpar_pkg::R_WAIT_PPS: begin
        if (div_done) state_next = tpar_pkg::R_MUL_NEW;
      end
      tpar_pkg::R_MUL_NEW:   state_next = tpar_pkg::R_MUL_OLD;
      tpar_pkg::R_MUL_OLD:   state_next = tpar_pkg::R_SUM;
      tpar_pkg::R_SUM:       state_next = tpar_pkg::R_ADJUST;
      tpar_pkg::R_ADJUST:    state_next = tpar_pkg::R_IDLE;
      default:               state_next = tpar_pkg::R_IDLE;
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {10'b0, mag100};
    div_divisor  = {6'b0, rated_eff};
    mul_a        = tpar_pkg::ONE_MINUS_ALPHA_Q16;
    mul_b        = avg;
    res.done     = 1'b0;
    res.delay    = delay_new;
    unique case (state)
      tpar_pkg::R_DIV_STEP: div_start = 1'b1;
      tpar_pkg::R_DIV_PPS: begin
        div_start    = 1'b1;
        div_dividend = {mag, 16'h0};
        div_divisor  = step_mag;
      end
      tpar_pkg::R_MUL_NEW: begin
        mul_a = tpar_pkg::ALPHA_Q16;
        mul_b = pps;
      end
      tpar_pkg::R_ADJUST: res.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpar_pkg::R_IDLE;
      avg   <= '0;
    end else begin
      state <= state_next;
      if (state == tpar_pkg::R_IDLE && req.start) begin
        power      <= req.power;
        rated      <= req.rated;
        delay_base <= req.delay;
      end
      if (state == tpar_pkg::R_WAIT_STEP && div_done) begin
        step_mag <= div_quo[21:0];
      end
      if (state == tpar_pkg::R_WAIT_PPS && div_done) begin
        pps <= (|div_quo[31:24]) ? 24'hFFFFFF : div_quo[23:0];
      end
      if (state == tpar_pkg::R_MUL_NEW || state == tpar_pkg::R_MUL_OLD) begin
        prod <= {24'b0, mul_a} * {16'b0, mul_b};
      end
      if (state == tpar_pkg::R_MUL_OLD) begin
        acc <= prod;
      end
      if (state == tpar_pkg::R_SUM) begin
        avg <= sum[39:16];
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/triac_phase_angle_regulator.sv @@
// Tick, zero-cross, force and unknown items: result registered on accept,
// one item per cycle while the output drains; a skid register holds a second.
// Power sample: the result passes through the 32-iteration divider once, or
// twice plus a two-pass multiplier when the per-step average is updated;
// no other item is taken until that result is loaded.
// Synchronous active-high reset restores control and state, not data registers.
`default_nettype none
`include "triac_phase_angle_regulator_assert.svh"

module triac_phase_angle_regulator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // power_watts[15:0], now_ms[47:16]
  input  wire logic [2:0]  s_tuser,  // operation[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // gate[0], opening_percent[7:1]
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] rated;
  logic [7:0]  holdoff;
  logic [7:0]  tick_count;
  logic [6:0]  delay;
  logic [31:0] last_zc;
  logic        gate;
  logic        busy;
  logic        skid_valid;
  logic [7:0]  skid_data;

  logic [7:0]  tick_next;
  logic [6:0]  delay_next;
  logic [31:0] last_zc_next;
  logic        gate_next;
  logic [31:0] elapsed;

  tpar_pkg::op_t      op;
  tpar_pkg::reg_req_t reg_req;
  tpar_pkg::reg_res_t reg_res;

  logic        accept;
  logic        res_load;
  logic [7:0]  res_word;

  assign op       = tpar_pkg::op_t'(s_tuser);
  assign s_tready = !busy && !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign elapsed  = s_tdata[47:16] - last_zc;

  always_comb begin
    tick_next    = tick_count;
    delay_next   = delay;
    last_zc_next = last_zc;
    gate_next    = gate;
    case (op)
      tpar_pkg::OP_TICK: begin
        if (tick_count != tpar_pkg::TICK_MAX) tick_next = tick_count + 8'd1;
        gate_next = (tick_next > {1'b0, delay}) && (delay < tpar_pkg::GATE_LIMIT);
      end
      tpar_pkg::OP_ZERO_CROSS: begin
        if (elapsed > {24'b0, holdoff}) begin
          tick_next    = 8'd0;
          last_zc_next = s_tdata[47:16];
          gate_next    = 1'b0;
        end
      end
      tpar_pkg::OP_FORCE_ON: begin
        delay_next = 7'd0;
        gate_next  = 1'b1;
      end
      tpar_pkg::OP_FORCE_OFF: begin
        delay_next = tpar_pkg::FULL_DELAY;
        gate_next  = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    reg_req.start = accept && (op == tpar_pkg::OP_POWER);
    reg_req.power = s_tdata[15:0];
    reg_req.rated = rated;
    reg_req.delay = delay;
  end

  tpar_regulator u_regulator (
    .clk (clk),
    .rst (rst),
    .req (reg_req),
    .res (reg_res)
  );

  always_comb begin
    res_load = (accept && (op != tpar_pkg::OP_POWER)) || reg_res.done;
    if (reg_res.done) begin
      res_word = {tpar_pkg::FULL_DELAY - reg_res.delay, gate};
    end else begin
      res_word = {tpar_pkg::FULL_DELAY - delay_next, gate_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rated      <= tpar_pkg::RATED_RESET;
      holdoff    <= tpar_pkg::HOLDOFF_RESET;
      tick_count <= '0;
      delay      <= tpar_pkg::FULL_DELAY;
      last_zc    <= '0;
      gate       <= 1'b0;
      busy       <= 1'b0;
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (tpar_pkg::cfg_index_t'(cfg_index))
          tpar_pkg::CFG_RATED:   rated   <= cfg_data;
          tpar_pkg::CFG_HOLDOFF: holdoff <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept && (op != tpar_pkg::OP_POWER)) begin
        tick_count <= tick_next;
        delay      <= delay_next;
        last_zc    <= last_zc_next;
        gate       <= gate_next;
      end
      if (reg_req.start) begin
        busy <= 1'b1;
      end else if (reg_res.done) begin
        busy  <= 1'b0;
        delay <= reg_res.delay;
      end
      // a new result never meets a full skid register
      if (res_load) begin
        if (!m_tvalid || m_tready) begin
          m_tdata  <= res_word;
          m_tvalid <= 1'b1;
        end else begin
          skid_data  <= res_word;
          skid_valid <= 1'b1;
        end
      end else if (m_tvalid && m_tready) begin
        if (skid_valid) begin
          m_tdata    <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          m_tvalid <= 1'b0;
        end
      end
    end
  end

  `TPAR_ASSERT_NEXT(a_power_busy, clk, rst, reg_req.start, busy, "power item did not start")
  `TPAR_ASSERT_IMP(a_done_busy, clk, rst, reg_res.done, busy, "regulator done while idle")
  `TPAR_ASSERT_IMP(a_skid_out, clk, rst, skid_valid, m_tvalid, "skid full with output empty")
  `TPAR_ASSERT_IMP(a_gate_rise, clk, rst, $rose(gate), $past(accept && (op == tpar_pkg::OP_TICK || op == tpar_pkg::OP_FORCE_ON)), "gate rose without tick or force on")

endmodule

`default_nettype wire

@@ tb/tb_triac_phase_angle_regulator.sv @@
`default_nettype none

module tb_triac_phase_angle_regulator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  OP_RSVD_A     = 3'd5;
  localparam logic [2:0]  OP_RSVD_B     = 3'd6;
  localparam logic [2:0]  OP_RSVD_C     = 3'd7;
  localparam logic [31:0] MAINS_HALF_MS = 32'd10;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 90;
  localparam int PHASES       = 6;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] power;
    logic [31:0] now;
  } mains_event_t;

  typedef struct packed {
    logic       gate;
    logic [6:0] opening;
  } drive_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] power;
    logic [31:0] now;
    logic [8:0]  reps;
    logic        fixed;
    logic        gate;
    logic [6:0]  opening;
  } script_row_t;

  // fixed = 1: expected drive typed in; fixed = 0: taken from the predictor
  localparam script_row_t SCRIPT [30] = '{
    '{tpar_pkg::OP_TICK,       16'd0,      32'd0,         9'd1,   1'b1, 1'b0, 7'd0},
    '{OP_RSVD_A,               16'd0,      32'd0,         9'd1,   1'b1, 1'b0, 7'd0},
    '{OP_RSVD_B,               16'hFFFF,   32'hFFFF_FFFF, 9'd1,   1'b1, 1'b0, 7'd0},
    '{tpar_pkg::OP_ZERO_CROSS, 16'd0,      32'd1,         9'd1,   1'b1, 1'b0, 7'd0},
    '{tpar_pkg::OP_ZERO_CROSS, 16'd0,      32'd3,         9'd1,   1'b1, 1'b0, 7'd0},
    '{tpar_pkg::OP_ZERO_CROSS, 16'd0,      32'hFFFF_FFFF, 9'd1,   1'b1, 1'b0, 7'd0},
    '{tpar_pkg::OP_ZERO_CROSS, 16'd0,      32'd0,         9'd1,   1'b1, 1'b0, 7'd0},
    '{tpar_pkg::OP_ZERO_CROSS, 16'd0,      32'd1,         9'd1,   1'b1, 1'b0, 7'd0},
    '{tpar_pkg::OP_ZERO_CROSS, 16'd0,      32'd2,         9'd1,   1'b1, 1'b0, 7'd0},
    '{tpar_pkg::OP_FORCE_ON,   16'd0,      32'd0,         9'd1,   1'b1, 1'b1, 7'd100},
    '{tpar_pkg::OP_TICK,       16'd0,      32'd0,         9'd300, 1'b1, 1'b1, 7'd100},
    '{tpar_pkg::OP_POWER,      16'd0,      32'd0,         9'd1,   1'b1, 1'b1, 7'd100},
    '{tpar_pkg::OP_POWER,      16'h7FFF,   32'd0,         9'd1,   1'b1, 1'b1, 7'd0},
    '{tpar_pkg::OP_TICK,       16'd0,      32'd0,         9'd1,   1'b1, 1'b0, 7'd0},
    '{tpar_pkg::OP_POWER,      16'h8000,   32'd0,         9'd1,   1'b1, 1'b0, 7'd100},
    '{tpar_pkg::OP_POWER,      16'(-1000), 32'd0,         9'd1,   1'b0, 1'b0, 7'd0},
    '{tpar_pkg::OP_POWER,      16'd20,     32'd0,         9'd1,   1'b0, 1'b0, 7'd0},
    '{tpar_pkg::OP_POWER,      16'd1,      32'd0,         9'd1,   1'b0, 1'b0, 7'd0},
    '{tpar_pkg::OP_POWER,      16'hFFFF,   32'd0,         9'd1,   1'b0, 1'b0, 7'd0},
    '{tpar_pkg::OP_FORCE_OFF,  16'd0,      32'd0,         9'd1,   1'b1, 1'b0, 7'd0},
    '{tpar_pkg::OP_ZERO_CROSS, 16'd0,      32'd100,       9'd1,   1'b1, 1'b0, 7'd0},
    '{tpar_pkg::OP_FORCE_ON,   16'd0,      32'd0,         9'd1,   1'b1, 1'b1, 7'd100},
    '{tpar_pkg::OP_POWER,      16'd1940,   32'd0,         9'd1,   1'b0, 1'b0, 7'd0},
    '{tpar_pkg::OP_TICK,       16'd0,      32'd0,         9'd100, 1'b0, 1'b0, 7'd0},
    '{tpar_pkg::OP_ZERO_CROSS, 16'd0,      32'd200,       9'd1,   1'b0, 1'b0, 7'd0},
    '{tpar_pkg::OP_FORCE_ON,   16'd0,      32'd0,         9'd1,   1'b1, 1'b1, 7'd100},
    '{tpar_pkg::OP_POWER,      16'd1960,   32'd0,         9'd1,   1'b0, 1'b0, 7'd0},
    '{tpar_pkg::OP_TICK,       16'd0,      32'd0,         9'd100, 1'b0, 1'b0, 7'd0},
    '{OP_RSVD_C,               16'd0,      32'd0,         9'd1,   1'b0, 1'b0, 7'd0},
    '{tpar_pkg::OP_FORCE_OFF,  16'd0,      32'd0,         9'd1,   1'b1, 1'b0, 7'd0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // power_watts[15:0], now_ms[47:16]
  logic [2:0]  s_tuser = '0;  // operation[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // gate[0], opening_percent[7:1]
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor state
  logic [7:0]  ticks_q   = '0;
  logic [6:0]  delay_q   = tpar_pkg::FULL_DELAY;
  logic [23:0] avg_q     = '0;
  logic [31:0] last_zc_q = '0;
  logic        gate_q    = 1'b0;
  logic [15:0] rated_q   = tpar_pkg::RATED_RESET;
  logic [7:0]  holdoff_q = tpar_pkg::HOLDOFF_RESET;

  drive_t      expected_drive[$];
  logic [31:0] mains_ms = 32'd300;
  int          burst_left = 0;
  int          mismatches = 0;
  int          quiet = 0;
  int          rx_mode = 0;
  int          rx_left = 0;

  triac_phase_angle_regulator i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void track_power(logic signed [15:0] pw);
    int              rated;
    int              stp;
    int              d;
    longint unsigned mag;
    longint unsigned pps;
    logic            below;
    rated = (rated_q == 16'd0) ? 1 : int'(rated_q);
    stp = (int'(pw) * 100) / rated;
    mag = (pw < 0) ? longint'(-int'(pw)) : longint'(pw);
    if (stp != 0 && stp < int'(tpar_pkg::GATE_LIMIT)) begin
      pps = (mag << 16) / longint'((stp < 0) ? -stp : stp);
      if (pps > 64'hFF_FFFF) pps = 64'hFF_FFFF;
      avg_q = 24'((64'(tpar_pkg::ALPHA_Q16) * pps
                   + 64'(tpar_pkg::ONE_MINUS_ALPHA_Q16) * 64'(avg_q)) >> 16);
    end
    below = (mag << 16) < 64'(avg_q);
    d = int'(delay_q);
    if (below && pw < 0) begin
      d = d;  // hold
    end else if (below && pw > 0) begin
      d = d + 1;
    end else begin
      if (stp > int'(tpar_pkg::STEP_LIMIT)) stp = int'(tpar_pkg::STEP_LIMIT);
      if (stp < -int'(tpar_pkg::STEP_LIMIT)) stp = -int'(tpar_pkg::STEP_LIMIT);
      d = d + stp;
    end
    if (d < 0) d = 0;
    if (d > int'(tpar_pkg::FULL_DELAY)) d = int'(tpar_pkg::FULL_DELAY);
    delay_q = 7'(d);
  endfunction

  function automatic drive_t next_drive(mains_event_t ev);
    case (ev.op)
      tpar_pkg::OP_TICK: begin
        if (ticks_q != tpar_pkg::TICK_MAX) ticks_q = ticks_q + 8'd1;
        gate_q = (ticks_q > {1'b0, delay_q}) && (delay_q < tpar_pkg::GATE_LIMIT);
      end
      tpar_pkg::OP_ZERO_CROSS: begin
        if ((ev.now - last_zc_q) > 32'(holdoff_q)) begin
          ticks_q = '0;
          last_zc_q = ev.now;
          gate_q = 1'b0;
        end
      end
      tpar_pkg::OP_POWER: track_power(ev.power);
      tpar_pkg::OP_FORCE_ON: begin
        delay_q = '0;
        gate_q = 1'b1;
      end
      tpar_pkg::OP_FORCE_OFF: begin
        delay_q = tpar_pkg::FULL_DELAY;
        gate_q = 1'b0;
      end
      default: ;
    endcase
    return drive_t'{gate_q, 7'(tpar_pkg::FULL_DELAY - delay_q)};
  endfunction

  task automatic send_event(mains_event_t ev, logic fixed, drive_t fixed_drive);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= ev.op;
    s_tdata  <= {ev.now, ev.power};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (fixed) begin
      void'(next_drive(ev));
      expected_drive.push_back(fixed_drive);
    end else begin
      expected_drive.push_back(next_drive(ev));
    end
  endtask

  task automatic write_reg(tpar_pkg::cfg_index_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == tpar_pkg::CFG_RATED) rated_q = val;
    else holdoff_q = val[7:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_power();
    int p;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: p = int'($urandom_range(0, 65535)) - 32768;
      2, 3, 4: p = int'($urandom_range(0, 400));
      5, 6, 7: p = (int'(rated_q) * (int'($urandom_range(0, 220)) - 110)) / 100
                   + int'($urandom_range(0, 4)) - 2;
      8: p = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: p = int'($urandom_range(1, 50));
    endcase
    if ((sel inside {2, 3, 4, 9}) && $urandom_range(0, 1) != 0) p = -p;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return 16'(p);
  endfunction

  function automatic logic [31:0] zc_interval();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return MAINS_HALF_MS;
    if (pick < 8) return 32'(holdoff_q) + 32'($urandom_range(0, 2));
    if (pick < 9) return 32'($urandom_range(0, 5));
    return $urandom;
  endfunction

  // half mains cycles: zero cross, then a run of ticks with events mixed in
  task automatic run_phase(int n_items);
    int          sent;
    int          n_ticks;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      mains_ms = mains_ms + zc_interval();
      send_event(mains_event_t'{tpar_pkg::OP_ZERO_CROSS, 16'($urandom), mains_ms},
                 1'b0, '0);
      sent++;
      n_ticks = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 300)
                                             : $urandom_range(0, 110);
      for (int k = 0; k < n_ticks; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          send_event(mains_event_t'{tpar_pkg::OP_POWER, rand_power(), $urandom},
                     1'b0, '0);
          sent++;
        end else if (pick < 13) begin
          send_event(mains_event_t'{tpar_pkg::OP_FORCE_ON, 16'($urandom), $urandom},
                     1'b0, '0);
          sent++;
        end else if (pick < 14) begin
          send_event(mains_event_t'{tpar_pkg::OP_FORCE_OFF, 16'($urandom), $urandom},
                     1'b0, '0);
          sent++;
        end else if (pick < 15) begin
          send_event(mains_event_t'{3'(OP_RSVD_A + 3'($urandom_range(0, 2))),
                                    16'($urandom), $urandom}, 1'b0, '0);
          sent++;
        end else if (pick < 17) begin
          send_event(mains_event_t'{tpar_pkg::OP_ZERO_CROSS, 16'($urandom),
                                    mains_ms + 32'($urandom_range(0, 3))}, 1'b0, '0);
          sent++;
        end
        send_event(mains_event_t'{tpar_pkg::OP_TICK, 16'($urandom), $urandom},
                   1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) != 0);
      default: m_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    drive_t got;
    drive_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.gate    = m_tdata[0];
        got.opening = m_tdata[7:1];
        if (expected_drive.size() == 0) begin
          note_mismatch($sformatf("unexpected result gate %0b opening %0d",
                                  got.gate, got.opening));
        end else begin
          want = expected_drive.pop_front();
          if (got.gate !== want.gate)
            note_mismatch($sformatf("gate expected %0b actual %0b", want.gate, got.gate));
          if (got.opening !== want.opening)
            note_mismatch($sformatf("opening expected %0d actual %0d",
                                    want.opening, got.opening));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (SCRIPT[i]) begin
      repeat (SCRIPT[i].reps)
        send_event(mains_event_t'{SCRIPT[i].op, SCRIPT[i].power, SCRIPT[i].now},
                   SCRIPT[i].fixed, drive_t'{SCRIPT[i].gate, SCRIPT[i].opening});
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: ;
        1: begin
          write_reg(tpar_pkg::CFG_RATED, 16'd1);
          write_reg(tpar_pkg::CFG_HOLDOFF, {8'($urandom), 8'd0});
        end
        2: begin
          write_reg(tpar_pkg::CFG_RATED, 16'hFFFF);
          write_reg(tpar_pkg::CFG_HOLDOFF, {8'($urandom), 8'hFF});
        end
        3: begin
          // zero rating behaves as one watt
          write_reg(tpar_pkg::CFG_RATED, 16'd0);
          write_reg(tpar_pkg::CFG_HOLDOFF, 16'($urandom));
        end
        4: begin
          write_reg(tpar_pkg::CFG_RATED, 16'($urandom_range(1, 65535)));
          write_reg(tpar_pkg::CFG_HOLDOFF, 16'($urandom));
        end
        default: begin
          write_reg(tpar_pkg::CFG_RATED, tpar_pkg::RATED_RESET);
          write_reg(tpar_pkg::CFG_HOLDOFF, {8'($urandom), tpar_pkg::HOLDOFF_RESET});
        end
      endcase
      run_phase(PHASE_ITEMS);
    end
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
